FILE: sv/light_barrier_passage_counter_macros.svh
// Assertion macros for the light barrier passage counter checker.
// Needs a signal named clock and a signal named reset in the using scope.
`ifndef LIGHT_BARRIER_PASSAGE_COUNTER_MACROS_SVH
`define LIGHT_BARRIER_PASSAGE_COUNTER_MACROS_SVH

// Checked only outside reset.
`define LBPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked also during reset.
`define LBPC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/lbpc_pkg.sv
// Package for the light barrier passage counter: payload structs, phase enum
// and reset constants. No dependencies.
package lbpc_pkg;

   localparam int TIME_WIDTH          = 32;
   localparam int GAP_WIDTH           = 24;
   localparam int OCC_WIDTH           = 16;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam logic [GAP_WIDTH-1:0] GAP_TIMEOUT_RESET = 24'd500000;

   localparam logic BARRIER_A   = 1'b0;
   localparam logic BARRIER_B   = 1'b1;
   localparam logic LEVEL_BROKEN = 1'b0;
   localparam logic LEVEL_CLEAR  = 1'b1;

   typedef struct packed {
      logic                  barrier;
      logic                  level;
      logic [TIME_WIDTH-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic [OCC_WIDTH-1:0] occupancy;
      logic                 went_up;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FWD,
      PH_REV
   } phase_type;

   // Event handed from the input register to the passage logic.
   typedef struct packed {
      logic    valid;
      req_type item;
   } evt_type;

   // Result handed from the passage logic to the output register.
   typedef struct packed {
      logic    valid;
      rsp_type item;
   } res_type;

endpackage

FILE: sv/lbpc_in_stage.sv
// Input register of the passage counter: holds one accepted edge event.
// Depends on lbpc_pkg.
module lbpc_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lbpc_pkg::req_type req_data,
   input  logic             advance,
   output lbpc_pkg::evt_type evt
);
   import lbpc_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;

   // Free when empty or when the held event moves on this cycle.
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         item_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign evt.valid = valid_ff;
   assign evt.item  = item_ff;

endmodule

FILE: sv/lbpc_core.sv
// Passage tracking: phase machine, last recorded event, gap check, count.
// Depends on lbpc_pkg.
module lbpc_core #(
   parameter int COUNT_WIDTH = lbpc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [lbpc_pkg::GAP_WIDTH-1:0]   csr_data,
   input  logic                             fire,
   input  lbpc_pkg::evt_type                evt,
   output lbpc_pkg::res_type                res
);
   import lbpc_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   phase_type             phase_ff, phase_in;
   logic                  have_rec_ff, have_rec_in;
   logic [TIME_WIDTH-1:0] rec_time_ff, rec_time_in;
   logic                  rec_barrier_ff, rec_barrier_in;
   logic                  rec_level_ff, rec_level_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [GAP_WIDTH-1:0]  gap_ff, gap_in;

   logic [TIME_WIDTH-1:0] elapsed;
   logic                  expired;
   logic                  count_up;
   logic                  count_down;
   phase_type             open_phase;

   assign elapsed = evt.item.time_us - rec_time_ff;
   assign expired = have_rec_ff &&
                    (elapsed > {{(TIME_WIDTH-GAP_WIDTH){1'b0}}, gap_ff});
   assign count_up   = (phase_ff == PH_FWD) && (rec_barrier_ff == BARRIER_B) &&
                       (rec_level_ff == LEVEL_CLEAR);
   assign count_down = (phase_ff == PH_REV) && (rec_barrier_ff == BARRIER_A) &&
                       (rec_level_ff == LEVEL_CLEAR);

   // Phase a new passage starts in; a non-falling edge leaves it idle.
   always_comb begin
      open_phase = PH_IDLE;
      if (evt.item.level == LEVEL_BROKEN) begin
         open_phase = (evt.item.barrier == BARRIER_A) ? PH_FWD : PH_REV;
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (phase_ff)
            PH_IDLE: phase_in = open_phase;
            PH_FWD,
            PH_REV:  phase_in = expired ? open_phase : phase_ff;
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // Recorded event, count and result
   always_comb begin
      have_rec_in    = have_rec_ff;
      rec_time_in    = rec_time_ff;
      rec_barrier_in = rec_barrier_ff;
      rec_level_in   = rec_level_ff;
      count_in       = count_ff;
      res.valid      = 1'b0;
      res.item.went_up = count_up;
      if (fire) begin
         case (phase_ff)
            PH_IDLE: begin
               have_rec_in = 1'b0;
            end
            PH_FWD,
            PH_REV: begin
               if (expired) begin
                  have_rec_in = 1'b0;
                  if (count_up) begin
                     res.valid = 1'b1;
                     if (count_ff != COUNT_MAX) count_in = count_ff + 1'b1;
                  end else if (count_down) begin
                     res.valid = 1'b1;
                     if (count_ff != '0) count_in = count_ff - 1'b1;
                  end
               end else begin
                  have_rec_in    = 1'b1;
                  rec_time_in    = evt.item.time_us;
                  rec_barrier_in = evt.item.barrier;
                  rec_level_in   = evt.item.level;
               end
            end
            default: begin
               have_rec_in = 1'b0;
            end
         endcase
      end
      // occupancy reports the low bits of the updated count
      res.item.occupancy = OCC_WIDTH'(count_in);
   end

   assign gap_in = csr_write ? csr_data : gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         have_rec_ff    <= 1'b0;
         rec_time_ff    <= '0;
         rec_barrier_ff <= 1'b0;
         rec_level_ff   <= 1'b0;
         count_ff       <= '0;
         gap_ff         <= GAP_TIMEOUT_RESET;
      end else begin
         phase_ff       <= phase_in;
         have_rec_ff    <= have_rec_in;
         rec_time_ff    <= rec_time_in;
         rec_barrier_ff <= rec_barrier_in;
         rec_level_ff   <= rec_level_in;
         count_ff       <= count_in;
         gap_ff         <= gap_in;
      end
   end

endmodule

FILE: sv/lbpc_out_stage.sv
// Output register of the passage counter: holds one result until taken.
// Depends on lbpc_pkg.
module lbpc_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  lbpc_pkg::res_type res,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lbpc_pkg::rsp_type rsp_data
);
   import lbpc_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type item_ff, item_in;
   logic    load;

   assign free = !valid_ff || rsp_ready;
   assign load = fire && res.valid;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = res.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = item_ff;

endmodule

FILE: sv/light_barrier_passage_counter.sv
// An accepted event is held in the input register; its result is then
// registered in the output register. One event per cycle unless the output
// register stalls; the passage update is combinational logic between them.
// Reset (synchronous, active high): idle phase, nothing recorded, count 0,
// gap timeout 500000 us, both registers empty.
// Depends on lbpc_pkg, lbpc_in_stage, lbpc_core, lbpc_out_stage.
module light_barrier_passage_counter #(
   parameter int COUNT_WIDTH = lbpc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // edge events
   input  logic                           req_valid,
   output logic                           req_ready,
   input  lbpc_pkg::req_type              req_data,
   // counted passages
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lbpc_pkg::rsp_type              rsp_data,
   // gap timeout register
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lbpc_pkg::GAP_WIDTH-1:0] csr_data
);
   import lbpc_pkg::*;

   evt_type evt;
   res_type res;
   logic    out_free;
   logic    fire;

   // The held event is processed once the output register can take a
   // result; events that produce no result still wait for that slot,
   // which keeps the result order trivially intact.
   assign fire = evt.valid && out_free;

   // The timeout register always takes a transfer.
   assign csr_ready = 1'b1;

   lbpc_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .advance   (fire),
      .evt       (evt)
   );

   lbpc_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .fire      (fire),
      .evt       (evt),
      .res       (res)
   );

   lbpc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .res       (res),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/lbpc_checker.sv
// Port-level checks for the light barrier passage counter, bound to the top.
// Depends on lbpc_pkg and light_barrier_passage_counter_macros.svh.
`include "light_barrier_passage_counter_macros.svh"

module lbpc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input lbpc_pkg::req_type              req_data,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input lbpc_pkg::rsp_type              rsp_data,
   input logic                           csr_ready
);
   import lbpc_pkg::*;

   `LBPC_ASSERT_ALWAYS(a_rsp_empty_after_reset, reset |=> !rsp_valid, "result after reset")
   `LBPC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")
   `LBPC_ASSERT(a_req_hold, req_valid && !req_ready |=> req_valid && $stable(req_data), "stalled event changed")
   `LBPC_ASSERT(a_csr_ready, csr_ready, "register port not ready")
   `LBPC_ASSERT(a_rsp_from_event, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2), "result without event transfer")

endmodule

bind light_barrier_passage_counter lbpc_checker u_lbpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
